[sv/msbkd_pkg.sv]
// Shared types and constants for the serial / block image / keyboard device.
// Holds the item and result word layouts, mode codes and the bus address map.
// No dependencies.
`timescale 1ns / 1ps

package msbkd_pkg;

  // Field widths of the item and result layouts and of the configuration port.
  localparam int MODE_W      = 2;
  localparam int DATA_W      = 32;
  localparam int LOAD_IDX_W  = 12;
  localparam int BYTE_W      = 8;
  localparam int IMG_SIZE_W  = 15;
  localparam int CFG_ADDR_W  = 3;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_BUS_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUS_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEY_EVENT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOAD_WORD = 2'd3;

  // Device register map.
  localparam logic [DATA_W-1:0] ADDR_ID0         = 32'h0000_0004;
  localparam logic [DATA_W-1:0] ADDR_ID1         = 32'h0000_0008;
  localparam logic [DATA_W-1:0] ADDR_SERIAL_STAT = 32'h0000_0018;
  localparam logic [DATA_W-1:0] ADDR_SERIAL_OUT  = 32'h0000_0020;
  localparam logic [DATA_W-1:0] ADDR_PTR_SET     = 32'h0000_0030;
  localparam logic [DATA_W-1:0] ADDR_IMAGE_DATA  = 32'h0000_0034;
  localparam logic [DATA_W-1:0] ADDR_KEY_STAT    = 32'h0000_0038;
  localparam logic [DATA_W-1:0] ADDR_KEY_CODE    = 32'h0000_003c;

  // Fixed read values.
  localparam logic [DATA_W-1:0] ID0_VALUE   = 32'h1234_5678;
  localparam logic [DATA_W-1:0] ID1_VALUE   = 32'habcd_ef9b;
  localparam logic [DATA_W-1:0] ALL_ONES    = 32'hffff_ffff;
  localparam logic [DATA_W-1:0] SERIAL_STAT = 32'h0000_0001;
  localparam logic [DATA_W-1:0] BYTE_MASK   = 32'h0000_00ff;

  // Configuration register index (word select bit of paddr).
  localparam logic REG_IMAGE_SIZE = 1'b0;

  // One input word.
  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [DATA_W-1:0]     bus_address;
    logic [DATA_W-1:0]     write_value;
    logic [DATA_W-1:0]     scan_code;
    logic [LOAD_IDX_W-1:0] load_index;
    logic [DATA_W-1:0]     load_word;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              serial_valid;
    logic [BYTE_W-1:0] serial_byte;
  } result_t;

endpackage

[sv/mmio_serial_block_keyboard_device.sv]
// Top level of the serial / block image / keyboard device.
// Depends on msbkd_pkg, msbkd_apb and msbkd_ram.
`timescale 1ns / 1ps

// The device takes one word per clock cycle (bus write, bus read, key event
// or image load) and gives exactly one result word for each, in the cycle
// after the word is accepted; the input is stalled only while a finished
// result waits on a stalled output. The image and keyboard ring memories
// have registered read ports, read in the cycle the word is accepted. No
// clearing pass runs after reset: image words and ring entries hold nothing
// defined until written, and the ring's head and tail pointers alone decide
// what is valid. The user must write the image size register through the
// APB-style port only while the device is idle; the block does not enforce it.
module mmio_serial_block_keyboard_device
  import msbkd_pkg::*;
#(
  parameter int KEY_DEPTH   = 32,
  parameter int IMAGE_WORDS = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam int KW = $clog2(KEY_DEPTH);
  localparam int IW = $clog2(IMAGE_WORDS);
  localparam logic [KW-1:0]     KEY_LAST    = KW'(KEY_DEPTH - 1);
  localparam logic [DATA_W-3:0] IMAGE_LIMIT = (DATA_W-2)'(IMAGE_WORDS);
  localparam logic [DATA_W-1:0] LOAD_LIMIT  = DATA_W'(IMAGE_WORDS);

  // Where the result's read data comes from.
  typedef enum logic [1:0] {
    SRC_REG,
    SRC_IMAGE,
    SRC_KEY
  } rd_src_t;

  logic [IMG_SIZE_W-1:0] image_size_bytes;
  logic [DATA_W-1:0]     block_pointer;
  logic [DATA_W-1:0]     block_pointer_next;
  logic [KW-1:0]         key_head;
  logic [KW-1:0]         key_head_next;
  logic [KW-1:0]         key_tail;
  logic [KW-1:0]         key_tail_next;
  logic [KW-1:0]         head_inc;
  logic [KW-1:0]         tail_inc;

  logic                  item_acc;
  logic                  is_write;
  logic                  is_read;
  logic                  ring_empty;
  logic                  ptr_in_range;
  logic                  image_rd;
  logic                  image_wr;
  logic                  key_push;
  logic                  key_pop;
  logic                  ptr_set;
  logic [DATA_W-1:0]     load_ext;
  logic [DATA_W-1:0]     image_q;
  logic [DATA_W-1:0]     key_q;

  rd_src_t               src_next;
  logic [DATA_W-1:0]     data_next;
  rd_src_t               res_src;
  logic [DATA_W-1:0]     res_data;
  logic                  res_serial_valid;
  logic [BYTE_W-1:0]     res_serial_byte;

  // Configuration register.
  msbkd_apb u_apb (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .image_size_bytes (image_size_bytes)
  );

  // Handshake: a new word enters unless a held result is stalled.
  assign item_stall = result_valid & result_stall;
  assign item_acc   = item_valid & ~item_stall;

  // Decode of the incoming word.
  assign is_write     = (item.mode == MODE_BUS_WRITE);
  assign is_read      = (item.mode == MODE_BUS_READ);
  assign ring_empty   = (key_head == key_tail);
  assign ptr_in_range = (block_pointer < {{(DATA_W-IMG_SIZE_W){1'b0}}, image_size_bytes}) &&
                        (block_pointer[DATA_W-1:2] < IMAGE_LIMIT);
  assign load_ext     = DATA_W'(item.load_index);

  assign image_rd = item_acc & is_read & (item.bus_address == ADDR_IMAGE_DATA) & ptr_in_range;
  assign key_pop  = item_acc & is_read & (item.bus_address == ADDR_KEY_CODE) & ~ring_empty;
  assign key_push = item_acc & (item.mode == MODE_KEY_EVENT);
  assign image_wr = item_acc & (item.mode == MODE_LOAD_WORD) & (load_ext < LOAD_LIMIT);
  assign ptr_set  = item_acc & is_write & (item.bus_address == ADDR_PTR_SET);

  // Ring pointer increments with wrap at the ring depth.
  assign head_inc = (key_head == KEY_LAST) ? '0 : key_head + 1'b1;
  assign tail_inc = (key_tail == KEY_LAST) ? '0 : key_tail + 1'b1;

  // Next state of the block pointer and the ring pointers.
  always_comb begin
    block_pointer_next = block_pointer;
    key_head_next      = key_head;
    key_tail_next      = key_tail;
    if (ptr_set) begin
      block_pointer_next = item.write_value;
    end else if (image_rd) begin
      block_pointer_next = block_pointer + DATA_W'(4);
    end
    if (key_push) begin
      key_head_next = head_inc;
      // A full ring drops its oldest entry.
      if (head_inc == key_tail) begin
        key_tail_next = tail_inc;
      end
    end else if (key_pop) begin
      key_tail_next = tail_inc;
    end
  end

  // Read data for everything that does not come from a memory.
  always_comb begin
    src_next  = SRC_REG;
    data_next = '0;
    if (is_read) begin
      unique case (item.bus_address)
        ADDR_ID0:         data_next = ID0_VALUE;
        ADDR_ID1:         data_next = ID1_VALUE;
        ADDR_SERIAL_STAT: data_next = SERIAL_STAT;
        ADDR_IMAGE_DATA: begin
          if (ptr_in_range) begin
            src_next = SRC_IMAGE;
          end else begin
            data_next = ALL_ONES;
          end
        end
        ADDR_KEY_STAT:    data_next = {{(DATA_W-1){1'b0}}, !ring_empty};
        ADDR_KEY_CODE: begin
          if (!ring_empty) begin
            src_next = SRC_KEY;
          end
        end
        default:          data_next = ALL_ONES;
      endcase
    end
  end

  // Block image memory.
  msbkd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (IMAGE_WORDS)
  ) u_image_ram (
    .clk     (clk),
    .wr_en   (image_wr),
    .wr_addr (load_ext[IW-1:0]),
    .wr_data (item.load_word),
    .rd_en   (image_rd),
    .rd_addr (block_pointer[IW+1:2]),
    .rd_data (image_q)
  );

  // Keyboard ring memory.
  msbkd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_push),
    .wr_addr (key_head),
    .wr_data (item.scan_code),
    .rd_en   (key_pop),
    .rd_addr (key_tail),
    .rd_data (key_q)
  );

  // Device state.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_pointer <= '0;
      key_head      <= '0;
      key_tail      <= '0;
    end else begin
      block_pointer <= block_pointer_next;
      key_head      <= key_head_next;
      key_tail      <= key_tail_next;
    end
  end

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_acc) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      res_src          <= src_next;
      res_data         <= data_next;
      res_serial_valid <= is_write & (item.bus_address == ADDR_SERIAL_OUT);
      res_serial_byte  <= (is_write && (item.bus_address == ADDR_SERIAL_OUT)) ?
                          item.write_value[BYTE_W-1:0] : '0;
    end
  end

  // Memory read data is held by the RAMs until the next read.
  always_comb begin
    result.serial_valid = res_serial_valid;
    result.serial_byte  = res_serial_byte;
    unique case (res_src)
      SRC_IMAGE: result.read_data = image_q;
      SRC_KEY:   result.read_data = key_q;
      default:   result.read_data = res_data;
    endcase
  end

`ifndef SYNTHESIS
  // After a key event the ring holds at least one code.
  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    key_push |=> (key_head != key_tail))
    else $error("ring empty after key event");

  // A scancode read on an empty ring leaves the ring alone.
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (item_acc && is_read && (item.bus_address == ADDR_KEY_CODE) && ring_empty)
      |=> $stable(key_tail) && $stable(key_head))
    else $error("ring changed by empty scancode read");

  // The block pointer moves only when a word is accepted.
  a_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    !item_acc |=> $stable(block_pointer))
    else $error("block pointer moved without an accepted word");

  // The input is held back only behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled without a pending result");

  // A serial byte never comes with read data.
  a_serial_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.serial_valid) |-> (result.read_data == '0))
    else $error("serial result carries read data");
`endif

endmodule

[sv/msbkd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the block image and the keyboard ring.
`timescale 1ns / 1ps

module msbkd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when not enabled.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/msbkd_apb.sv]
// APB-style configuration port holding the image size register.
// Depends on msbkd_pkg.
`timescale 1ns / 1ps

module msbkd_apb
  import msbkd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  output logic [IMG_SIZE_W-1:0] image_size_bytes
);

  logic wr_hit;

  // The access phase completes without wait states: pready is tied high.
  assign pready = 1'b1;
  assign wr_hit = psel & penable & pwrite & (paddr[2] == REG_IMAGE_SIZE);

  // Image size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size_bytes <= '0;
    end else if (wr_hit) begin
      image_size_bytes <= pwdata[IMG_SIZE_W-1:0];
    end
  end

  // Read back; unmapped words read as zero.
  assign prdata = (paddr[2] == REG_IMAGE_SIZE) ?
                  {{(DATA_W-IMG_SIZE_W){1'b0}}, image_size_bytes} : '0;

endmodule
